// File: hdl/acia_pkg.sv
// Package for the serial interface core: opcodes, register addresses, flag masks,
// request and response payload types. No dependencies.
`timescale 1ns / 1ps
package acia_pkg;
   localparam int BitCyclesWidth = 16;
   localparam logic [BitCyclesWidth-1:0] BitCyclesReset = 16'd1024;
   localparam int CountWidth = 24;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      REG_DATA    = 2'd0,
      REG_STATUS  = 2'd1,
      REG_COMMAND = 2'd2,
      REG_CONTROL = 2'd3
   } reg_addr_type;

   localparam logic [4:0] ST_PE   = 5'h01;
   localparam logic [4:0] ST_FE   = 5'h02;
   localparam logic [4:0] ST_OVRN = 5'h04;
   localparam logic [4:0] ST_RDRF = 5'h08;
   localparam logic [4:0] ST_TDRE = 5'h10;

   localparam logic [7:0] CMD_KEEP_MASK = 8'hE0;
   localparam logic [1:0] TIC_OFF   = 2'b00;
   localparam logic [1:0] TIC_IRQ   = 2'b01;
   localparam logic [1:0] TIC_BREAK = 2'b11;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [1:0]  reg_addr;
      logic [7:0]  write_value;
      logic [15:0] elapsed_cycles;
      logic        rx_valid;
      logic [7:0]  rx_byte;
      logic        rx_parity_error;
      logic        rx_framing_error;
      logic        rxd_line;
      logic        cts_line;
      logic        dcd_line;
      logic        dsr_line;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       txd_line;
      logic       rts_line;
      logic       dtr_line;
      logic       break_out;
      logic       irq_out;
      logic [2:0] parity_mode;
      logic [3:0] data_bits;
      logic [2:0] stop_half_bits;
   } rsp_type;

   // Character length in half bits for the given command and control bytes.
   function automatic logic [5:0] char_half_bits(input logic [7:0] cmd, input logic [7:0] ctl);
      logic [3:0] db;
      logic [2:0] sh;
      logic       pe;
      db = 4'd8 - {2'b00, ctl[6:5]};
      pe = cmd[5];
      if (!ctl[7]) sh = 3'd2;
      else if (db == 4'd5 && !pe) sh = 3'd3;
      else if (db == 4'd8 && pe) sh = 3'd2;
      else sh = 3'd4;
      return 6'd2 + {1'b0, db, 1'b0} + (pe ? 6'd2 : 6'd0) + {3'b000, sh};
   endfunction
endpackage

// File: hdl/acia_if.sv
// Valid/ready channel interface carrying one payload of a given type.
// No dependencies; the payload type is a parameter.
`timescale 1ns / 1ps
interface acia_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/acia_regs.sv
// Register state and single-pass next-state logic of the serial interface.
// Depends on acia_pkg.
`timescale 1ns / 1ps
module acia_regs (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  acia_pkg::req_type            req,
   input  logic [acia_pkg::BitCyclesWidth-1:0] bit_cycles,
   output acia_pkg::rsp_type            rsp
);
   import acia_pkg::*;

   logic [7:0] rx_data_ff, rx_data_in, tx_data_ff, tx_data_in;
   logic [4:0] status_ff, status_in;
   logic [7:0] cmd_ff, cmd_in, ctl_ff, ctl_in;
   logic       irq_ff, irq_in, busy_ff, busy_in;
   logic [CountWidth-1:0] txcnt_ff, txcnt_in, ecnt_ff, ecnt_in;
   logic       epend_ff, epend_in, elev_ff, elev_in;
   logic       rxd_ff, rxd_in, txd_ff, txd_in, dcd_ff, dcd_in, dsr_ff, dsr_in;
   logic       mlat_ff, mlat_in, mdcd_ff, mdcd_in, mdsr_ff, mdsr_in;

   logic [16:0] half;
   logic [CountWidth-1:0] load_cnt;
   logic       txv;
   logic [7:0] rdata;
   logic       rx_irq_en;

   assign half = {req.elapsed_cycles, 1'b0};
   assign load_cnt = {8'h00, bit_cycles} * {18'd0, char_half_bits(cmd_ff, ctl_ff)};
   assign rx_irq_en = cmd_ff[0] && !cmd_ff[1];

   always_comb begin
      rx_data_in = rx_data_ff; tx_data_in = tx_data_ff; status_in = status_ff;
      cmd_in = cmd_ff; ctl_in = ctl_ff; irq_in = irq_ff; busy_in = busy_ff;
      txcnt_in = txcnt_ff; ecnt_in = ecnt_ff; epend_in = epend_ff; elev_in = elev_ff;
      rxd_in = rxd_ff; txd_in = txd_ff; dcd_in = dcd_ff; dsr_in = dsr_ff;
      mlat_in = mlat_ff; mdcd_in = mdcd_ff; mdsr_in = mdsr_ff;
      txv = 1'b0; rdata = 8'h00;
      case (opcode_type'(req.opcode))
         OP_TICK: begin
            if (busy_ff) begin
               if (txcnt_ff <= CountWidth'(half)) begin
                  txcnt_in = '0; txv = 1'b1; busy_in = 1'b0;
                  status_in = status_in | ST_TDRE;
               end else begin
                  txcnt_in = txcnt_ff - CountWidth'(half);
               end
            end
            if (cmd_ff[4]) begin
               logic [CountWidth-1:0] ec;
               logic ep;
               ec = ecnt_ff; ep = epend_ff;
               if (req.rxd_line != rxd_ff) begin
                  elev_in = req.rxd_line; ep = 1'b1; ec = CountWidth'(bit_cycles);
               end
               if (ep) begin
                  if (ec <= CountWidth'(half)) begin
                     ec = '0; ep = 1'b0;
                     txd_in = (req.rxd_line != rxd_ff) ? req.rxd_line : elev_ff;
                  end else begin
                     ec = ec - CountWidth'(half);
                  end
               end
               ecnt_in = ec; epend_in = ep;
            end else begin
               epend_in = 1'b0; ecnt_in = '0;
            end
            rxd_in = req.rxd_line;
            if (!mlat_ff && (req.dcd_line != dcd_ff || req.dsr_line != dsr_ff)) begin
               mdcd_in = req.dcd_line; mdsr_in = req.dsr_line; mlat_in = 1'b1;
               if (rx_irq_en) irq_in = 1'b1;
            end
            dcd_in = req.dcd_line; dsr_in = req.dsr_line;
            if (req.rx_valid) begin
               if ((status_ff & ST_RDRF) != '0) status_in = status_in | ST_OVRN;
               rx_data_in = req.rx_byte;
               status_in = status_in | ST_RDRF;
               if (req.rx_parity_error) status_in = status_in | ST_PE;
               if (req.rx_framing_error) status_in = status_in | ST_FE;
               if (rx_irq_en) irq_in = 1'b1;
            end
            if (cmd_ff[0] && cmd_ff[3:2] == TIC_IRQ && (status_in & ST_TDRE) != '0)
               irq_in = 1'b1;
         end
         OP_READ: begin
            case (reg_addr_type'(req.reg_addr))
               REG_DATA: begin
                  rdata = rx_data_ff;
                  status_in = status_ff & ~(ST_RDRF | ST_OVRN | ST_FE | ST_PE);
                  if (cmd_ff[0] && cmd_ff[3:2] == TIC_IRQ && (status_ff & ST_TDRE) != '0)
                     irq_in = 1'b1;
               end
               REG_STATUS: begin
                  rdata = {irq_ff, mlat_ff ? mdsr_ff : dsr_ff,
                           mlat_ff ? mdcd_ff : dcd_ff, status_ff};
                  irq_in = 1'b0;
                  if (mlat_ff) begin
                     mlat_in = 1'b0;
                     if (dcd_ff != mdcd_ff || dsr_ff != mdsr_ff) begin
                        mdcd_in = dcd_ff; mdsr_in = dsr_ff; mlat_in = 1'b1;
                        if (!cmd_ff[1]) irq_in = 1'b1;
                     end
                  end
               end
               REG_COMMAND: rdata = cmd_ff;
               default: rdata = ctl_ff;
            endcase
         end
         OP_WRITE: begin
            case (reg_addr_type'(req.reg_addr))
               REG_DATA: begin
                  if (!(cmd_ff[4] || cmd_ff[3:2] == TIC_OFF || cmd_ff[3:2] == TIC_BREAK
                        || busy_ff)) begin
                     tx_data_in = req.write_value;
                     status_in = status_ff & ~ST_TDRE;
                     busy_in = 1'b1;
                     txcnt_in = load_cnt;
                  end
               end
               REG_STATUS: begin
                  cmd_in = cmd_ff & CMD_KEEP_MASK;
                  status_in = status_ff & ~ST_OVRN;
                  irq_in = 1'b0;
                  if (cmd_in[0] && cmd_in[3:2] == TIC_IRQ && (status_in & ST_TDRE) != '0)
                     irq_in = 1'b1;
               end
               REG_COMMAND: begin
                  cmd_in = req.write_value;
                  if (cmd_in[0] && cmd_in[3:2] == TIC_IRQ && (status_ff & ST_TDRE) != '0)
                     irq_in = 1'b1;
               end
               default: ctl_in = req.write_value;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_data_ff <= '0; tx_data_ff <= '0; status_ff <= ST_TDRE;
         cmd_ff <= '0; ctl_ff <= '0; irq_ff <= 1'b0; busy_ff <= 1'b0;
         txcnt_ff <= '0; ecnt_ff <= '0; epend_ff <= 1'b0; elev_ff <= 1'b1;
         rxd_ff <= 1'b1; txd_ff <= 1'b1; dcd_ff <= 1'b0; dsr_ff <= 1'b0;
         mlat_ff <= 1'b0; mdcd_ff <= 1'b0; mdsr_ff <= 1'b0;
      end else if (step) begin
         rx_data_ff <= rx_data_in; tx_data_ff <= tx_data_in; status_ff <= status_in;
         cmd_ff <= cmd_in; ctl_ff <= ctl_in; irq_ff <= irq_in; busy_ff <= busy_in;
         txcnt_ff <= txcnt_in; ecnt_ff <= ecnt_in; epend_ff <= epend_in; elev_ff <= elev_in;
         rxd_ff <= rxd_in; txd_ff <= txd_in; dcd_ff <= dcd_in; dsr_ff <= dsr_in;
         mlat_ff <= mlat_in; mdcd_ff <= mdcd_in; mdsr_ff <= mdsr_in;
      end
   end

   always_comb begin
      logic [3:0] db;
      db = 4'd8 - {2'b00, ctl_in[6:5]};
      rsp.read_data = rdata;
      rsp.tx_valid = txv;
      rsp.tx_byte = txv ? tx_data_ff : 8'h00;
      rsp.txd_line = txd_in;
      rsp.rts_line = !cmd_in[4] && cmd_in[3:2] == TIC_OFF;
      rsp.dtr_line = !cmd_in[0];
      rsp.break_out = !cmd_in[4] && cmd_in[3:2] == TIC_BREAK;
      rsp.irq_out = irq_in;
      rsp.parity_mode = cmd_in[5] ? {1'b0, cmd_in[7:6]} + 3'd1 : 3'd0;
      rsp.data_bits = db;
      if (!ctl_in[7]) rsp.stop_half_bits = 3'd2;
      else if (db == 4'd5 && !cmd_in[5]) rsp.stop_half_bits = 3'd3;
      else if (db == 4'd8 && cmd_in[5]) rsp.stop_half_bits = 3'd2;
      else rsp.stop_half_bits = 3'd4;
   end
endmodule

// File: hdl/acia_serial_interface_core.sv
// Top level of the serial interface core: input register, register file
// and response register. Depends on acia_pkg, acia_if and acia_regs.
`timescale 1ns / 1ps
// Usage:
//   req (sink): one request per handshake: a tick, a bus read or a bus write.
//   rsp (source): exactly one response per request, in order.
//   csr (sink): writes bit_cycles, the clock cycles per serial bit. The
//     user writes only while the block is idle (unchecked). Always ready.
// Path: a taken request is held in the input register, worked through the
//   state logic, and its response is registered in the response register.
// Throughput: one request per cycle unless stalled; a single pass of
//   flag and counter logic (one 16x6 multiply loads the character timer).
// Stall: the input register accepts a new request while it is empty or
//   the response register is empty or being drained in the same cycle;
//   while the receiver holds off, the input register holds its request
//   and req.ready drops.
// Reset: synchronous; clears both pipeline valids, sets bit_cycles to 1024,
//   status to transmit-empty only, the line levels rxd and txd high.
module acia_serial_interface_core #(
   parameter logic [acia_pkg::BitCyclesWidth-1:0] BIT_CYCLES_RESET = acia_pkg::BitCyclesReset
) (
   input logic clock,
   input logic reset,
   acia_if.sink   req,
   acia_if.source rsp,
   acia_if.sink   csr
);
   import acia_pkg::*;

   logic [BitCyclesWidth-1:0] bitc_ff;
   req_type in_ff;
   logic    in_vld_ff;
   rsp_type out_ff, out_in;
   logic    out_vld_ff;
   logic    step;

   // Advance the held request once the response slot is free.
   assign step = in_vld_ff && (!out_vld_ff || rsp.ready);
   assign req.ready = !in_vld_ff || step;
   assign csr.ready = 1'b1;
   assign rsp.valid = out_vld_ff;
   assign rsp.payload = out_ff;

   acia_regs u_regs (
      .clock(clock), .reset(reset), .step(step), .req(in_ff),
      .bit_cycles(bitc_ff), .rsp(out_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         bitc_ff <= BIT_CYCLES_RESET;
         in_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (csr.valid) bitc_ff <= csr.payload;
         if (req.ready) in_vld_ff <= req.valid;
         if (step) out_vld_ff <= 1'b1;
         else if (rsp.ready) out_vld_ff <= 1'b0;
      end
      if (req.ready && req.valid) in_ff <= req.payload;
      if (step) out_ff <= out_in;
   end
endmodule

// File: dv/acia_serial_interface_core_tb.sv
// Self-checking testbench for acia_serial_interface_core: directed and random requests,
// bit time changes, receiver back-pressure. Depends on acia_pkg, acia_if and the core.
`timescale 1ns / 1ps
module acia_serial_interface_core_tb;
   import acia_pkg::*;

   localparam int StallLimit = 2000;   // cycles without any handshake before giving up
   localparam int LongHold   = 200;    // receiver hold-off for the back-pressure test

   logic clock = 1'b0;
   logic reset = 1'b1;

   acia_if #(.payload_type(req_type))     req ();
   acia_if #(.payload_type(rsp_type))     rsp ();
   acia_if #(.payload_type(logic [15:0])) csr ();

   acia_serial_interface_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source),
      .csr   (csr.sink)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow copy of the core's registers and flags
   logic [15:0] bit_time;
   logic [7:0]  rx_hold, tx_hold, cmd_reg, ctl_reg;
   logic [4:0]  flags;
   logic        irq_pend, tx_sending, echo_armed, echo_val;
   int unsigned tx_left, echo_left;
   logic        lvl_rxd, lvl_txd, lvl_cts, lvl_dcd, lvl_dsr;
   logic        mdm_held, mdm_dcd, mdm_dsr;

   rsp_type     expected_rsp[$];
   int          errors = 0;
   int          requests_sent = 0, responses_seen = 0, chars_sent = 0;
   bit          quiet = 1'b0;        // no idling on either side
   bit          want_hold = 1'b0;    // ask the receiver for one long hold-off

   function automatic logic [3:0] char_bits();
      return 4'd8 - {2'b00, ctl_reg[6:5]};
   endfunction

   function automatic logic [2:0] parity_sel();
      return cmd_reg[5] ? {1'b0, cmd_reg[7:6]} + 3'd1 : 3'd0;
   endfunction

   function automatic logic [2:0] stop_halves();
      if (!ctl_reg[7]) return 3'd2;
      if (char_bits() == 4'd5 && !cmd_reg[5]) return 3'd3;
      if (char_bits() == 4'd8 && cmd_reg[5]) return 3'd2;
      return 3'd4;
   endfunction

   function automatic bit rx_irq_on();
      return cmd_reg[0] && !cmd_reg[1];
   endfunction

   function automatic void raise_tx_irq();
      if (cmd_reg[0] && cmd_reg[3:2] == TIC_IRQ && (flags & ST_TDRE) != 0) irq_pend = 1'b1;
   endfunction

   function automatic void clear_shadow();
      bit_time = BitCyclesReset;
      rx_hold = '0; tx_hold = '0; cmd_reg = '0; ctl_reg = '0;
      flags = ST_TDRE;
      irq_pend = 1'b0; tx_sending = 1'b0; tx_left = 0;
      echo_armed = 1'b0; echo_val = 1'b1; echo_left = 0;
      lvl_rxd = 1'b1; lvl_txd = 1'b1; lvl_cts = 1'b0; lvl_dcd = 1'b0; lvl_dsr = 1'b0;
      mdm_held = 1'b0; mdm_dcd = 1'b0; mdm_dsr = 1'b0;
   endfunction

   // Advance the shadow state by one request and return the response it produces.
   function automatic rsp_type predict_response(req_type r);
      rsp_type     o;
      int unsigned halves;
      logic [7:0]  st;
      o = '0;
      halves = int'(r.elapsed_cycles) * 2;
      case (opcode_type'(r.opcode))
         OP_TICK: begin
            if (tx_sending) begin
               if (tx_left <= halves) begin
                  tx_left = 0;
                  o.tx_valid = 1'b1;
                  o.tx_byte = tx_hold;
                  tx_sending = 1'b0;
                  flags |= ST_TDRE;
               end else tx_left -= halves;
            end
            if (cmd_reg[4]) begin
               if (r.rxd_line != lvl_rxd) begin
                  echo_val = r.rxd_line;
                  echo_armed = 1'b1;
                  echo_left = bit_time;
               end
               if (echo_armed) begin
                  if (echo_left <= halves) begin
                     echo_left = 0;
                     lvl_txd = echo_val;
                     echo_armed = 1'b0;
                  end else echo_left -= halves;
               end
            end else begin
               echo_armed = 1'b0;
               echo_left = 0;
            end
            lvl_rxd = r.rxd_line;
            lvl_cts = r.cts_line;
            if (!mdm_held && (r.dcd_line != lvl_dcd || r.dsr_line != lvl_dsr)) begin
               mdm_dcd = r.dcd_line;
               mdm_dsr = r.dsr_line;
               mdm_held = 1'b1;
               if (rx_irq_on()) irq_pend = 1'b1;
            end
            lvl_dcd = r.dcd_line;
            lvl_dsr = r.dsr_line;
            if (r.rx_valid) begin
               if ((flags & ST_RDRF) != 0) flags |= ST_OVRN;
               rx_hold = r.rx_byte;
               flags |= ST_RDRF;
               if (r.rx_parity_error) flags |= ST_PE;
               if (r.rx_framing_error) flags |= ST_FE;
               if (rx_irq_on()) irq_pend = 1'b1;
            end
            raise_tx_irq();
         end
         OP_READ: begin
            case (reg_addr_type'(r.reg_addr))
               REG_DATA: begin
                  o.read_data = rx_hold;
                  flags &= ~(ST_RDRF | ST_OVRN | ST_FE | ST_PE);
                  raise_tx_irq();
               end
               REG_STATUS: begin
                  st = {irq_pend, mdm_held ? mdm_dsr : lvl_dsr,
                        mdm_held ? mdm_dcd : lvl_dcd, flags};
                  o.read_data = st;
                  irq_pend = 1'b0;
                  if (mdm_held) begin
                     mdm_held = 1'b0;
                     if (lvl_dcd != mdm_dcd || lvl_dsr != mdm_dsr) begin
                        mdm_dcd = lvl_dcd;
                        mdm_dsr = lvl_dsr;
                        mdm_held = 1'b1;
                        if (!cmd_reg[1]) irq_pend = 1'b1;
                     end
                  end
               end
               REG_COMMAND: o.read_data = cmd_reg;
               default: o.read_data = ctl_reg;
            endcase
         end
         OP_WRITE: begin
            case (reg_addr_type'(r.reg_addr))
               REG_DATA: begin
                  // drop the byte while sending, echoing, sending a break, or with the transmitter off
                  if (!(cmd_reg[4] || cmd_reg[3:2] == TIC_OFF || cmd_reg[3:2] == TIC_BREAK
                        || tx_sending)) begin
                     tx_hold = r.write_value;
                     flags &= ~ST_TDRE;
                     tx_sending = 1'b1;
                     tx_left = int'(bit_time) * (2 + 2 * int'(char_bits())
                               + (parity_sel() != 0 ? 2 : 0) + int'(stop_halves()));
                     raise_tx_irq();
                  end
               end
               REG_STATUS: begin
                  cmd_reg &= CMD_KEEP_MASK;
                  flags &= ~ST_OVRN;
                  irq_pend = 1'b0;
                  raise_tx_irq();
               end
               REG_COMMAND: begin
                  cmd_reg = r.write_value;
                  raise_tx_irq();
               end
               default: ctl_reg = r.write_value;
            endcase
         end
         default: ;
      endcase
      o.txd_line = lvl_txd;
      o.rts_line = !cmd_reg[4] && cmd_reg[3:2] == TIC_OFF;
      o.dtr_line = !cmd_reg[0];
      o.break_out = !cmd_reg[4] && cmd_reg[3:2] == TIC_BREAK;
      o.irq_out = irq_pend;
      o.parity_mode = parity_sel();
      o.data_bits = char_bits();
      o.stop_half_bits = stop_halves();
      return o;
   endfunction

   function automatic void compare_field(string name, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         errors++;
      end
   endfunction

   // Check every response against the oldest prediction; watch for a hang.
   int idle_cycles = 0;
   always @(posedge clock) begin
      rsp_type want, got;
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            got = rsp.payload;
            responses_seen++;
            if (got.tx_valid) chars_sent++;
            if (expected_rsp.size() == 0) begin
               $error("response with no request outstanding");
               errors++;
            end else begin
               want = expected_rsp.pop_front();
               compare_field("read_data", want.read_data, got.read_data);
               compare_field("tx_valid", want.tx_valid, got.tx_valid);
               compare_field("tx_byte", want.tx_byte, got.tx_byte);
               compare_field("txd_line", want.txd_line, got.txd_line);
               compare_field("rts_line", want.rts_line, got.rts_line);
               compare_field("dtr_line", want.dtr_line, got.dtr_line);
               compare_field("break_out", want.break_out, got.break_out);
               compare_field("irq_out", want.irq_out, got.irq_out);
               compare_field("parity_mode", want.parity_mode, got.parity_mode);
               compare_field("data_bits", want.data_bits, got.data_bits);
               compare_field("stop_half_bits", want.stop_half_bits, got.stop_half_bits);
            end
         end
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= StallLimit) begin
            $display("Timeout: no handshake for %0d cycles", StallLimit);
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Response side: random stall bursts plus one long hold-off on request.
   int stall_left = 0;
   int hold_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b1;
      end else if (want_hold) begin
         want_hold = 1'b0;
         hold_left = LongHold;
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
         stall_left = int'($urandom_range(0, 14));
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   // Offer one request, hold it until taken, then maybe idle for a burst.
   task automatic send_request(req_type r);
      @(negedge clock);
      req.payload <= r;
      req.valid <= 1'b1;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      expected_rsp.push_back(predict_response(r));
      requests_sent++;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         @(negedge clock);
         req.valid <= 1'b0;
         repeat ($urandom_range(0, 14)) @(negedge clock);
      end
   endtask

   // Drop valid, drain all responses and let the pipeline settle.
   task automatic wait_drained();
      @(negedge clock);
      req.valid <= 1'b0;
      wait (expected_rsp.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_bit_time(logic [15:0] value);
      wait_drained();
      @(negedge clock);
      csr.payload <= value;
      csr.valid <= 1'b1;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      bit_time = value;
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   function automatic req_type make_request(opcode_type op, reg_addr_type addr,
                                            logic [7:0] value);
      req_type r;
      r = '0;
      r.opcode = op;
      r.reg_addr = addr;
      r.write_value = value;
      r.rxd_line = lvl_rxd;
      r.dcd_line = lvl_dcd;
      r.dsr_line = lvl_dsr;
      return r;
   endfunction

   function automatic req_type make_tick(logic [15:0] cycles);
      req_type r;
      r = make_request(OP_TICK, REG_DATA, 8'h00);
      r.elapsed_cycles = cycles;
      return r;
   endfunction

   // Random request, biased toward useful traffic: transmit setups, ticks, reads.
   function automatic req_type random_request();
      req_type r;
      int pick;
      r = '0;
      r.reg_addr = 2'($urandom_range(0, 3));
      r.write_value = 8'($urandom_range(0, 255));
      pick = int'($urandom_range(0, 99));
      if (pick < 50) begin
         r.opcode = OP_TICK;
         r.elapsed_cycles = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 65535))
                                                         : 16'($urandom_range(0, 60));
         r.rx_valid = $urandom_range(0, 3) == 0;
         r.rx_byte = 8'($urandom_range(0, 255));
         r.rx_parity_error = $urandom_range(0, 5) == 0;
         r.rx_framing_error = $urandom_range(0, 5) == 0;
         r.rxd_line = ($urandom_range(0, 3) == 0) ? !lvl_rxd : lvl_rxd;
         r.cts_line = 1'($urandom_range(0, 1));
         r.dcd_line = ($urandom_range(0, 7) == 0) ? !lvl_dcd : lvl_dcd;
         r.dsr_line = ($urandom_range(0, 7) == 0) ? !lvl_dsr : lvl_dsr;
      end else if (pick < 75) begin
         r.opcode = OP_READ;
      end else if (pick < 98) begin
         r.opcode = OP_WRITE;
         // keep the command mostly in a transmitting, interrupting setup
         if (r.reg_addr == REG_COMMAND && $urandom_range(0, 2) != 0)
            r.write_value = {r.write_value[7:5], 1'b0, TIC_IRQ, r.write_value[1], 1'b1};
         if (r.reg_addr == REG_STATUS && $urandom_range(0, 1) == 0) r.reg_addr = REG_DATA;
      end else begin
         r.opcode = OP_NONE;
      end
      return r;
   endfunction

   task automatic test_reset_values();
      for (int a = 0; a < 4; a++) send_request(make_request(OP_READ, reg_addr_type'(a), 8'h00));
      send_request(make_request(OP_NONE, REG_DATA, 8'hFF));
   endtask

   task automatic test_directed();
      req_type r;
      send_request(make_request(OP_WRITE, REG_CONTROL, 8'hFF));       // 5 bits, long stop
      send_request(make_request(OP_WRITE, REG_COMMAND, 8'h05));       // dtr on, tx irq
      send_request(make_request(OP_WRITE, REG_DATA, 8'hA5));
      send_request(make_request(OP_WRITE, REG_DATA, 8'h5A));          // dropped while busy
      send_request(make_tick(16'd0));
      send_request(make_tick(16'hFFFF));
      send_request(make_request(OP_WRITE, REG_CONTROL, 8'h80));       // 8 bits, long stop
      send_request(make_request(OP_WRITE, REG_COMMAND, 8'hED));       // parity, break
      send_request(make_request(OP_WRITE, REG_DATA, 8'h11));          // dropped: break
      r = make_tick(16'd1);
      r.rx_valid = 1'b1; r.rx_byte = 8'hFF; r.rx_parity_error = 1'b1;
      send_request(r);
      r.rx_byte = 8'h00; r.rx_parity_error = 1'b0; r.rx_framing_error = 1'b1;
      send_request(r);                                                 // overrun
      send_request(make_request(OP_READ, REG_STATUS, 8'h00));
      send_request(make_request(OP_WRITE, REG_STATUS, 8'h00));        // programmed reset
      send_request(make_request(OP_READ, REG_DATA, 8'h00));
      r = make_tick(16'd3);
      r.dcd_line = 1'b1; r.dsr_line = 1'b1; r.cts_line = 1'b1;
      send_request(r);
      r.dcd_line = 1'b0;
      send_request(r);
      send_request(make_request(OP_READ, REG_STATUS, 8'h00));
      send_request(make_request(OP_READ, REG_STATUS, 8'h00));
      send_request(make_request(OP_WRITE, REG_COMMAND, 8'h17));       // echo mode
      send_request(make_request(OP_WRITE, REG_DATA, 8'h33));          // dropped: echo
      r = make_tick(16'd0); r.rxd_line = 1'b0;
      send_request(r);
      send_request(make_tick(16'd2000));
      send_request(make_request(OP_READ, REG_COMMAND, 8'h00));
   endtask

   // Run with a chosen bit time, extremes included, and check a character and random requests.
   task automatic test_bit_time(logic [15:0] value, int count);
      set_bit_time(value);
      send_request(make_request(OP_WRITE, REG_COMMAND, 8'h05));
      send_request(make_request(OP_WRITE, REG_DATA, 8'h3C));
      send_request(make_tick(16'd0));
      send_request(make_tick(16'd1));
      for (int i = 0; i < count; i++) send_request(random_request());
      send_request(make_tick(16'hFFFF));
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 250 == 0) set_bit_time(16'($urandom_range(1, 24)));
         send_request(random_request());
      end
   endtask

   task automatic test_backpressure();
      want_hold = 1'b1;
      for (int i = 0; i < 40; i++) send_request(random_request());
   endtask

   initial begin
      req.valid = 1'b0; req.payload = '0;
      csr.valid = 1'b0; csr.payload = '0;
      rsp.ready = 1'b1;
      clear_shadow();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_values();
      test_directed();
      test_bit_time(16'd1, 60);
      test_bit_time(16'hFFFF, 20);
      test_bit_time(16'd0, 60);          // zero bit time: countdowns expire at once
      test_backpressure();
      test_random(1500);
      quiet = 1'b1;
      test_bit_time(16'd4, 300);
      wait_drained();
      repeat (10) @(posedge clock);

      $display("Covered %0d requests, %0d responses, %0d characters sent,",
               requests_sent, responses_seen, chars_sent);
      $display("bit times 0, 1, 65535 and random, with stalls and a long receiver hold-off");
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

// File: files.f
hdl/acia_pkg.sv
hdl/acia_if.sv
hdl/acia_regs.sv
hdl/acia_serial_interface_core.sv
dv/acia_serial_interface_core_tb.sv
